### rtl/core/assert_macros.svh
// Assertion macros shared by the console RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge out of reset.
`define TCCS_ASSERT(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define TCCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/core/tccs_pkg.sv
// Types and constants for the text console cursor/scroll block.
// No dependencies; imported by the top level, by tccs_ctrl and by the bench.
`default_nettype none

package tccs_pkg;

    localparam logic       OP_PUT       = 1'b0;
    localparam logic       OP_READ      = 1'b1;
    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam logic [7:0] SPACE_CODE   = 8'h20;
    localparam logic [7:0] ATTR_RESET   = 8'h07;
    localparam logic [15:0] RESET_BLANK = 16'h0720;

    typedef struct packed {
        logic       op;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } t_in;

    typedef struct packed {
        logic [15:0] cell_value;
        logic [4:0]  cursor_row_out;
        logic [6:0]  cursor_col_out;
        logic        scrolled;
    } t_out;

endpackage

`default_nettype wire

### rtl/core/text_console_cursor_scroll.sv
// Text console writer: cursor tracking, character store, scroll-up.
// Top level; uses tccs_pkg and tccs_ctrl.
//
// Use: items arrive on i_in_valid/o_in_ready/i_in_data; each produces one
// result on o_out_valid/i_out_ready/o_out_data. Op put writes a character
// (or a newline) at the cursor; op read returns one cell of the store.
// i_cfg_we/i_cfg_wdata write the attribute byte (reset 0x07). A put or an
// out-of-range read goes from idle to the done state, an in-range read
// through the read state first; the result then enters the output register.
// A put that runs past the last row scrolls the screen: the copy reads and
// writes one cell per cycle on the single store port pair.
// One item is in work at a time; o_in_ready is high only while the
// sequencer is idle.
// After reset a clearing pass writes blank cells to the whole store, with
// o_in_ready low; attribute writes are taken meanwhile. A result waits in
// the output register while the receiver stalls, and the next item is still
// accepted and worked on until its own result is ready.
`default_nettype none

module text_console_cursor_scroll #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output      logic           o_in_ready,
    input  wire tccs_pkg::t_in  i_in_data,
    output      logic           o_out_valid,
    input  wire logic           i_out_ready,
    output      tccs_pkg::t_out o_out_data,
    input  wire logic           i_cfg_we,
    input  wire logic [7:0]     i_cfg_wdata
);

    import tccs_pkg::*;

    logic [7:0] r_attr;
    logic       r_out_valid;
    t_out       r_out_data;
    logic       res_valid;
    logic       res_ready;
    t_out       res;

    tccs_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_attr      (r_attr),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // take a new result when the output register is empty or draining
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr      <= ATTR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_attr <= i_cfg_wdata;
            end
            if (res_ready) begin
                r_out_valid <= res_valid;
            end
        end
        if (res_valid && res_ready) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

### rtl/core/tccs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tccs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/core/tccs_ctrl.sv
// Sequencer of the console: cursor, put/read operations, clearing pass
// and scroll copy through one shared address counter. Uses tccs_pkg, tccs_ram.
`default_nettype none
`include "assert_macros.svh"

module tccs_ctrl #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output      logic          o_in_ready,
    input  wire tccs_pkg::t_in i_in_data,
    input  wire logic [7:0]    i_attr,
    output      logic          o_res_valid,
    input  wire logic          i_res_ready,
    output      tccs_pkg::t_out o_res
);

    import tccs_pkg::*;

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int CNT_W      = $clog2(CELL_COUNT + 1);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int COL_W      = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int LAST_ROW   = (ROWS - 1) * COLUMNS;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_COPY  = 3'd3;
    localparam logic [2:0] S_FILL  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]        r_state,    n_state;
    logic [CNT_W-1:0]  r_ptr,      n_ptr;
    logic              r_pend,     n_pend;
    logic [ADDR_W-1:0] r_waddr,    n_waddr;
    logic [ROW_W-1:0]  r_row,      n_row;
    logic [COL_W-1:0]  r_col,      n_col;
    logic [ADDR_W-1:0] r_cur_addr, n_cur_addr;
    logic [15:0]       r_cell,     n_cell;
    logic              r_scrolled, n_scrolled;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [15:0]       ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [15:0]       ram_rdata;

    logic [31:0]       rd_addr32;
    logic              rd_in_range;
    logic              is_nl;
    logic              wrap;
    logic [31:0]       nl_addr32;
    logic [31:0]       row32;
    logic [31:0]       col32;

    tccs_ram #(
        .WIDTH (16),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign row32       = 32'(r_row);
    assign col32       = 32'(r_col);
    assign rd_addr32   = 32'(i_in_data.read_row) * COLUMNS + 32'(i_in_data.read_col);
    assign rd_in_range = (32'(i_in_data.read_row) < ROWS) &&
                         (32'(i_in_data.read_col) < COLUMNS);
    assign is_nl       = (i_in_data.char_code == NEWLINE_CODE);
    assign wrap        = is_nl || (col32 == COLUMNS - 1);
    assign nl_addr32   = 32'(r_cur_addr) - col32 + COLUMNS;

    always_comb begin
        n_state    = r_state;
        n_ptr      = r_ptr;
        n_pend     = 1'b0;
        n_waddr    = r_waddr;
        n_row      = r_row;
        n_col      = r_col;
        n_cur_addr = r_cur_addr;
        n_cell     = r_cell;
        n_scrolled = r_scrolled;
        ram_we     = 1'b0;
        ram_waddr  = r_cur_addr;
        ram_wdata  = {i_attr, i_in_data.char_code};
        ram_raddr  = rd_addr32[ADDR_W-1:0];
        o_in_ready = 1'b0;
        o_res_valid = 1'b0;
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_ptr[ADDR_W-1:0];
                ram_wdata = RESET_BLANK;
                n_ptr     = r_ptr + CNT_W'(1);
                if (r_ptr == CNT_W'(CELL_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_cell     = 16'h0000;
                    n_scrolled = 1'b0;
                    if (i_in_data.op == OP_READ) begin
                        n_state = rd_in_range ? S_READ : S_DONE;
                    end else begin
                        // write the character at the cursor, newline writes nothing
                        ram_we  = !is_nl;
                        n_state = S_DONE;
                        if (wrap && (row32 == ROWS - 1)) begin
                            n_col      = '0;
                            n_cur_addr = ADDR_W'(LAST_ROW);
                            n_scrolled = 1'b1;
                            n_ptr      = CNT_W'(COLUMNS);
                            n_state    = S_COPY;
                        end else if (wrap) begin
                            n_col      = '0;
                            n_row      = r_row + ROW_W'(1);
                            n_cur_addr = nl_addr32[ADDR_W-1:0];
                        end else begin
                            n_col      = r_col + COL_W'(1);
                            n_cur_addr = r_cur_addr + ADDR_W'(1);
                        end
                    end
                end
            end
            S_READ: begin
                n_cell  = ram_rdata;
                n_state = S_DONE;
            end
            S_COPY: begin
                // read one cell ahead, write it one row up in the next cycle
                ram_we    = r_pend;
                ram_waddr = r_waddr;
                ram_wdata = ram_rdata;
                if (r_ptr != CNT_W'(CELL_COUNT)) begin
                    ram_raddr = r_ptr[ADDR_W-1:0];
                    n_ptr     = r_ptr + CNT_W'(1);
                    n_pend    = 1'b1;
                    n_waddr   = ADDR_W'(r_ptr - CNT_W'(COLUMNS));
                end else begin
                    n_ptr   = CNT_W'(LAST_ROW);
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = r_ptr[ADDR_W-1:0];
                ram_wdata = {i_attr, SPACE_CODE};
                n_ptr     = r_ptr + CNT_W'(1);
                if (r_ptr == CNT_W'(CELL_COUNT - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_ptr      <= '0;
            r_pend     <= 1'b0;
            r_row      <= '0;
            r_col      <= '0;
            r_cur_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_ptr      <= n_ptr;
            r_pend     <= n_pend;
            r_row      <= n_row;
            r_col      <= n_col;
            r_cur_addr <= n_cur_addr;
        end
        r_waddr    <= n_waddr;
        r_cell     <= n_cell;
        r_scrolled <= n_scrolled;
    end

    always_comb begin
        o_res                = '0;
        o_res.cell_value     = r_cell;
        o_res.cursor_row_out = row32[4:0];
        o_res.cursor_col_out = col32[6:0];
        o_res.scrolled       = r_scrolled;
    end

    `TCCS_ASSERT(a_cursor_range, i_clk, i_rst_n,
        (row32 < ROWS) && (col32 < COLUMNS), "cursor out of range")
    `TCCS_ASSERT(a_cursor_addr, i_clk, i_rst_n,
        32'(r_cur_addr) == row32 * COLUMNS + col32, "cursor address out of step")
    `TCCS_ASSERT_IMP(a_scroll_cursor, i_clk, i_rst_n,
        (r_state == S_DONE) && r_scrolled, (row32 == ROWS - 1) && (col32 == 0),
        "scroll left cursor off last row start")
    `TCCS_ASSERT_IMP(a_copy_target, i_clk, i_rst_n,
        (r_state == S_COPY) && r_pend, 32'(r_waddr) < LAST_ROW,
        "scroll copy wrote into last row")

endmodule

`default_nettype wire

### tb/tb_text_console_cursor_scroll.sv
// Self-checking bench for text_console_cursor_scroll: puts, newlines, wraps, scrolls and
// cell reads, checked against a shadow screen kept in the bench. Depends on tccs_pkg and
// the block's RTL only.
`default_nettype none

module tb_text_console_cursor_scroll;
    import tccs_pkg::*;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int PHASES  = 6;
    localparam int PHASE_ITEMS = 80;
    localparam int DIRECTED_COUNT = 20;
    localparam int LONG_HOLD_CYCLES = 3000;

    typedef struct {
        t_in  item;
        bit   typed;
        t_out want;
    } t_directed_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;
    logic i_cfg_we = 1'b0;
    logic [7:0] i_cfg_wdata = '0;

    // Shadow of the screen store, cursor and attribute register
    logic [15:0] screen_image [ROWS*COLUMNS];
    int          shadow_row;
    int          shadow_col;
    logic [7:0]  shadow_attr;

    t_out pending_results [$];
    int   error_count = 0;
    int   sender_max_gap = 0;
    int   receiver_max_stall = 0;
    bit   long_hold_request = 1'b0;

    t_directed_row directed_rows [DIRECTED_COUNT];
    int phase_gap [PHASES]          = '{18, 0, 18, 4, 18, 0};
    int phase_stall [PHASES]        = '{18, 18, 0, 4, 18, 0};
    int phase_newline_odds [PHASES] = '{3, 6, 100, 4, 100, 8};

    text_console_cursor_scroll #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_out predict_console(input t_in item);
        t_out res;
        int   i;
        res = '0;
        if (item.op == OP_READ) begin
            if (item.read_row < ROWS && item.read_col < COLUMNS) begin
                res.cell_value = screen_image[item.read_row * COLUMNS + item.read_col];
            end
        end else begin
            if (item.char_code == NEWLINE_CODE) begin
                shadow_col = 0;
                shadow_row++;
            end else begin
                screen_image[shadow_row * COLUMNS + shadow_col] = {shadow_attr, item.char_code};
                shadow_col++;
                if (shadow_col >= COLUMNS) begin
                    shadow_col = 0;
                    shadow_row++;
                end
            end
            if (shadow_row >= ROWS) begin
                for (i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
                    screen_image[i] = screen_image[i + COLUMNS];
                end
                for (i = (ROWS - 1) * COLUMNS; i < ROWS * COLUMNS; i++) begin
                    screen_image[i] = {shadow_attr, SPACE_CODE};
                end
                shadow_row   = ROWS - 1;
                res.scrolled = 1'b1;
            end
        end
        res.cursor_row_out = 5'(shadow_row);
        res.cursor_col_out = 7'(shadow_col);
        return res;
    endfunction

    // Offer one item after a gap; returns at the falling edge after the transfer
    task automatic send_item(input t_in item, input bit typed, input t_out want, input int gap);
        t_out predicted;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = predict_console(item);
        pending_results.push_back(typed ? want : predicted);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic write_attribute(input logic [7:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow_attr = value;
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        int stall;
        forever begin
            @(negedge i_clk);
            stall = $urandom_range(0, receiver_max_stall);
            if (long_hold_request) begin
                long_hold_request = 1'b0;
                stall = LONG_HOLD_CYCLES;
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with no expectation waiting: %h", o_out_data);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.cell_value !== want.cell_value) begin
                    $error("cell_value: expected %h, got %h", want.cell_value,
                           o_out_data.cell_value);
                    error_count++;
                end
                if (o_out_data.cursor_row_out !== want.cursor_row_out) begin
                    $error("cursor_row_out: expected %0d, got %0d", want.cursor_row_out,
                           o_out_data.cursor_row_out);
                    error_count++;
                end
                if (o_out_data.cursor_col_out !== want.cursor_col_out) begin
                    $error("cursor_col_out: expected %0d, got %0d", want.cursor_col_out,
                           o_out_data.cursor_col_out);
                    error_count++;
                end
                if (o_out_data.scrolled !== want.scrolled) begin
                    $error("scrolled: expected %b, got %b", want.scrolled, o_out_data.scrolled);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #60_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        t_in  item;
        int   phase;
        int   n;
        int   gap;

        foreach (screen_image[i]) screen_image[i] = RESET_BLANK;
        shadow_row  = 0;
        shadow_col  = 0;
        shadow_attr = ATTR_RESET;

        // Reset contents, range edges, extreme codes, newline; typed rows first
        directed_rows = '{
            '{'{OP_READ, 8'h00, 5'd0, 7'd0},    1'b1, '{16'h0720, 5'd0, 7'd0, 1'b0}},
            '{'{OP_READ, 8'hFF, 5'd24, 7'd79},  1'b1, '{16'h0720, 5'd0, 7'd0, 1'b0}},
            '{'{OP_READ, 8'h00, 5'd25, 7'd0},   1'b1, '{16'h0000, 5'd0, 7'd0, 1'b0}},
            '{'{OP_READ, 8'h00, 5'd0, 7'd80},   1'b1, '{16'h0000, 5'd0, 7'd0, 1'b0}},
            '{'{OP_READ, 8'h00, 5'd31, 7'd127}, 1'b1, '{16'h0000, 5'd0, 7'd0, 1'b0}},
            '{'{OP_PUT, 8'h41, 5'd31, 7'd127},  1'b1, '{16'h0000, 5'd0, 7'd1, 1'b0}},
            '{'{OP_READ, 8'h00, 5'd0, 7'd0},    1'b1, '{16'h0741, 5'd0, 7'd1, 1'b0}},
            '{'{OP_PUT, 8'h00, 5'd0, 7'd0},     1'b1, '{16'h0000, 5'd0, 7'd2, 1'b0}},
            '{'{OP_PUT, 8'hFF, 5'd0, 7'd0},     1'b1, '{16'h0000, 5'd0, 7'd3, 1'b0}},
            '{'{OP_PUT, NEWLINE_CODE, 5'd0, 7'd0}, 1'b1, '{16'h0000, 5'd1, 7'd0, 1'b0}},
            '{'{OP_READ, 8'h00, 5'd0, 7'd1},    1'b1, '{16'h0700, 5'd1, 7'd0, 1'b0}},
            '{'{OP_READ, 8'h00, 5'd0, 7'd2},    1'b1, '{16'h07FF, 5'd1, 7'd0, 1'b0}},
            '{'{OP_READ, 8'h00, 5'd0, 7'd3},    1'b1, '{16'h0720, 5'd1, 7'd0, 1'b0}},
            '{'{OP_PUT, NEWLINE_CODE, 5'd5, 7'd9}, 1'b1, '{16'h0000, 5'd2, 7'd0, 1'b0}},
            '{'{OP_PUT, 8'h0B, 5'd0, 7'd0},     1'b0, '0},
            '{'{OP_PUT, 8'h09, 5'd0, 7'd0},     1'b0, '0},
            '{'{OP_READ, 8'hAA, 5'd2, 7'd0},    1'b0, '0},
            '{'{OP_READ, 8'h55, 5'd24, 7'd0},   1'b0, '0},
            '{'{OP_PUT, SPACE_CODE, 5'd0, 7'd0}, 1'b0, '0},
            '{'{OP_READ, 8'h00, 5'd2, 7'd79},   1'b0, '0}
        };

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        sender_max_gap     = 3;
        receiver_max_stall = 3;
        foreach (directed_rows[r]) begin
            send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want,
                      $urandom_range(0, sender_max_gap));
        end

        for (phase = 0; phase < PHASES; phase++) begin
            drain_results();
            case (phase)
                0:       write_attribute(8'hFF);
                1:       write_attribute(8'h00);
                default: write_attribute(8'($urandom_range(0, 255)));
            endcase
            sender_max_gap     = phase_gap[phase];
            receiver_max_stall = phase_stall[phase];
            // Hold the output while items keep coming, so the block backs up
            if (phase == 1) long_hold_request = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                item = '0;
                item.read_row  = 5'($urandom_range(0, 31));
                item.read_col  = 7'($urandom_range(0, 127));
                item.char_code = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 3) == 0) begin
                    item.op = OP_READ;
                    if ($urandom_range(0, 7) != 0) begin
                        item.read_row = 5'($urandom_range(0, ROWS - 1));
                        item.read_col = 7'($urandom_range(0, COLUMNS - 1));
                    end
                end else begin
                    item.op = OP_PUT;
                    if ($urandom_range(0, phase_newline_odds[phase] - 1) == 0) begin
                        item.char_code = NEWLINE_CODE;
                    end
                end
                gap = $urandom_range(0, sender_max_gap);
                // Pause the sender until every result is back
                if (phase == 3 && n == 40) begin
                    drain_results();
                end
                send_item(item, 1'b0, '0, gap);
            end
        end

        drain_results();
        repeat (2100) @(negedge i_clk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
